[rtl/btlv_pkg.sv]
// shared types and constants for the ber-tlv stream parser
package btlv_pkg;

  localparam int unsigned MaxTagBytes    = 4;
  localparam int unsigned MaxLengthBytes = 2;

  typedef enum logic [2:0] {
    PH_TAG_FIRST = 3'd0,
    PH_TAG_MORE  = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_MORE  = 3'd3,
    PH_VALUE     = 3'd4,
    PH_ERR_TAG   = 3'd5,
    PH_ERR_LEN   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CLS_TAG     = 2'd0,
    CLS_LENGTH  = 2'd1,
    CLS_VALUE   = 2'd2,
    CLS_IGNORED = 2'd3
  } byte_class_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TAG_LONG = 2'd1,
    ERR_LEN_FORM = 2'd2
  } error_code_e;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] tag_accum;
    logic [2:0]  tag_count;
    logic [15:0] length_accum;
    logic [1:0]  len_left;
    logic [15:0] value_pos;
    logic [2:0]  header_count;
  } parse_state_t;

  typedef struct packed {
    byte_class_e byte_class;
    logic [31:0] tag_word;
    logic [2:0]  tag_byte_count;
    logic [15:0] decoded_len;
    logic [7:0]  value_out;
    logic [15:0] value_index;
    logic [2:0]  header_length;
    logic        item_done;
    error_code_e error_code;
  } parse_result_t;

endpackage

[rtl/btlv_step.sv]
// next parser state and result for one stream byte
module btlv_step (
  input  btlv_pkg::parse_state_t  state_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    frame_start_i,
  output btlv_pkg::parse_state_t  state_o,
  output btlv_pkg::parse_result_t result_o
);
  import btlv_pkg::*;

  always_comb begin
    parse_state_t s;
    byte_class_e  cls;
    error_code_e  err;
    logic [7:0]   vout;
    logic [15:0]  vidx;
    logic         done;
    logic [6:0]   n;
    logic         fin;

    s    = state_i;
    cls  = CLS_TAG;
    err  = ERR_NONE;
    vout = 8'd0;
    vidx = 16'd0;
    done = 1'b0;
    n    = data_byte_i[6:0];
    fin  = 1'b0;

    if (frame_start_i) begin
      s.phase = PH_TAG_FIRST;
    end

    unique case (s.phase)
      PH_TAG_FIRST: begin
        cls            = CLS_TAG;
        s.tag_accum    = {24'd0, data_byte_i};
        s.tag_count    = 3'd1;
        s.header_count = 3'd1;
        s.length_accum = 16'd0;
        s.len_left     = 2'd0;
        s.value_pos    = 16'd0;
        s.phase        = (data_byte_i[4:0] == 5'h1f) ? PH_TAG_MORE : PH_LEN_FIRST;
      end
      PH_TAG_MORE: begin
        cls = CLS_TAG;
        if (s.tag_count >= 3'(MaxTagBytes)) begin
          err     = ERR_TAG_LONG;
          s.phase = PH_ERR_TAG;
        end else begin
          s.tag_accum    = {s.tag_accum[23:0], data_byte_i};
          s.tag_count    = s.tag_count + 3'd1;
          s.header_count = s.header_count + 3'd1;
          if (!data_byte_i[7]) begin
            s.phase = PH_LEN_FIRST;
          end
        end
      end
      PH_LEN_FIRST: begin
        cls = CLS_LENGTH;
        if (data_byte_i[7]) begin
          if (n == 7'd0 || n > 7'(MaxLengthBytes)) begin
            err     = ERR_LEN_FORM;
            s.phase = PH_ERR_LEN;
          end else begin
            s.header_count = s.header_count + 3'd1;
            s.length_accum = 16'd0;
            s.len_left     = n[1:0];
            s.phase        = PH_LEN_MORE;
          end
        end else begin
          s.header_count = s.header_count + 3'd1;
          s.length_accum = {8'd0, data_byte_i};
          fin            = 1'b1;
        end
      end
      PH_LEN_MORE: begin
        cls            = CLS_LENGTH;
        s.header_count = s.header_count + 3'd1;
        s.length_accum = {s.length_accum[7:0], data_byte_i};
        if (s.len_left != 2'd0) begin
          s.len_left = s.len_left - 2'd1;
        end
        fin = (s.len_left == 2'd0);
      end
      PH_VALUE: begin
        cls         = CLS_VALUE;
        vout        = data_byte_i;
        vidx        = s.value_pos;
        s.value_pos = s.value_pos + 16'd1;
        // end of value field, or index wrapped
        if (s.value_pos == s.length_accum || s.value_pos == 16'd0) begin
          done    = 1'b1;
          s.phase = PH_TAG_FIRST;
        end
      end
      PH_ERR_TAG: begin
        cls = CLS_IGNORED;
        err = ERR_TAG_LONG;
      end
      default: begin
        s.phase = PH_ERR_LEN;
        cls     = CLS_IGNORED;
        err     = ERR_LEN_FORM;
      end
    endcase

    // length field complete: zero length ends the item here
    if (fin) begin
      if (s.length_accum == 16'd0) begin
        done    = 1'b1;
        s.phase = PH_TAG_FIRST;
      end else begin
        s.value_pos = 16'd0;
        s.phase     = PH_VALUE;
      end
    end

    state_o                 = s;
    result_o.byte_class     = cls;
    result_o.tag_word       = s.tag_accum;
    result_o.tag_byte_count = s.tag_count;
    result_o.decoded_len    = s.length_accum;
    result_o.value_out      = vout;
    result_o.value_index    = vidx;
    result_o.header_length  = s.header_count;
    result_o.item_done      = done;
    result_o.error_code     = err;
  end

endmodule

[rtl/ber_tlv_stream_parser_core.sv]
// ber-tlv stream parser top level: input register, parse step, result register
// an accepted request is held in the input register, then its result in the result register
// throughput: one byte per cycle while results are drained; parser state feeds back through one step of logic
// the input register advances whenever the result register is empty or being drained
// reset (async, active low) empties both registers and returns the parser to expect
// a first tag byte with all accumulators cleared
module ber_tlv_stream_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  // result request channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  byte_class_o,
  output logic [31:0] tag_word_o,
  output logic [2:0]  tag_byte_count_o,
  output logic [15:0] decoded_len_o,
  output logic [7:0]  value_out_o,
  output logic [15:0] value_index_o,
  output logic [2:0]  header_length_o,
  output logic        item_done_o,
  output logic [1:0]  error_code_o
);
  import btlv_pkg::*;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // parser state
  parse_state_t state_q, state_d;

  // result register
  logic          out_valid_q, out_valid_d;
  parse_result_t res_q, res_d;

  logic out_space;
  logic advance;
  logic take_in;

  // result slot free now or freed this cycle
  assign out_space  = !out_valid_q || out_ready_i;
  // registered byte moves through the parse step
  assign advance    = in_valid_q && out_space;
  assign in_ready_o = !in_valid_q || advance;
  assign take_in    = in_valid_i && in_ready_o;

  btlv_step u_step (
    .state_i       (state_q),
    .data_byte_i   (in_byte_q),
    .frame_start_i (in_start_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (take_in) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q             <= 1'b0;
      out_valid_q            <= 1'b0;
      state_q.phase          <= PH_TAG_FIRST;
      state_q.tag_accum      <= 32'd0;
      state_q.tag_count      <= 3'd0;
      state_q.length_accum   <= 16'd0;
      state_q.len_left       <= 2'd0;
      state_q.value_pos      <= 16'd0;
      state_q.header_count   <= 3'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= frame_start_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_class_o     = res_q.byte_class;
  assign tag_word_o       = res_q.tag_word;
  assign tag_byte_count_o = res_q.tag_byte_count;
  assign decoded_len_o    = res_q.decoded_len;
  assign value_out_o      = res_q.value_out;
  assign value_index_o    = res_q.value_index;
  assign header_length_o  = res_q.header_length;
  assign item_done_o      = res_q.item_done;
  assign error_code_o     = res_q.error_code;

endmodule
